/* rtl/core/turm_pkg.sv */
`timescale 1ns / 1ps

package turm_pkg;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [2:0] SEL_RBR = 3'd0;
    localparam logic [2:0] SEL_THR = 3'd1;
    localparam logic [2:0] SEL_LSR = 3'd2;
    localparam logic [2:0] SEL_IER = 3'd3;
    localparam logic [2:0] SEL_IIR = 3'd4;
    localparam logic [2:0] SEL_LCR = 3'd5;

    localparam logic [7:0] FLAG_RX_FULL  = 8'h80;
    localparam logic [7:0] FLAG_TX_EMPTY = 8'h40;
    localparam logic [7:0] LSR_RESET     = 8'h40;
    localparam logic [7:0] CHAR_CR       = 8'd13;
    localparam logic [7:0] CHAR_LF       = 8'd10;
    localparam logic [7:0] CHAR_LC_A     = 8'h61;
    localparam logic [7:0] CHAR_LC_Z     = 8'h7a;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = 2;
    localparam int OBUF_CW    = 3;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic       rx_valid;
        logic [7:0] rx_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_char;
        logic       irq;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic      en;
        logic      two;
        t_out_item first;
        t_out_item second;
    } t_push;

endpackage

/* rtl/core/terminal_uart_register_model.sv */
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------
// input    | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
// output   | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// One item per cycle while the result buffer has room; a tick that sends a
// carriage return yields two results, so it takes two entries on the output side.
// Results are registered in a four-entry result buffer; input is taken
// while it has room for two results.
// Synchronous active-low reset; no clearing pass.
module terminal_uart_register_model (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  turm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output turm_pkg::t_out_item o_out_item
);

    logic            accept;
    turm_pkg::t_push push;

    assign accept = i_in_valid && o_in_ready;

    turm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push)
    );

    turm_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    a_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty result buffer");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result buffer not empty after reset");

    a_tx_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.tx_valid |-> o_out_item.tx_char == 8'd0)
        else $error("tx_char set without tx_valid");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.read_data != 8'd0
            |-> !o_out_item.tx_valid && !o_out_item.irq && o_out_item.last)
        else $error("read data mixed with tick result");

endmodule

/* rtl/core/turm_core.sv */
`timescale 1ns / 1ps

module turm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  turm_pkg::t_in_item i_item,
    output turm_pkg::t_push   o_push
);

    logic [7:0] r_rbr, r_thr, r_lsr, r_ier, r_iir, r_lcr;
    logic [7:0] n_rbr, n_thr, n_lsr, n_ier, n_iir, n_lcr;
    logic [7:0] rd;
    logic [7:0] rx_c;
    logic       irq;
    logic       tx_go;
    logic       is_cr;

    always_comb begin
        n_rbr = r_rbr;
        n_thr = r_thr;
        n_lsr = r_lsr;
        n_ier = r_ier;
        n_iir = r_iir;
        n_lcr = r_lcr;
        rd    = 8'd0;
        irq   = 1'b0;
        tx_go = 1'b0;
        rx_c  = i_item.rx_char;
        if (i_item.rx_char >= turm_pkg::CHAR_LC_A && i_item.rx_char <= turm_pkg::CHAR_LC_Z) begin
            rx_c = i_item.rx_char - turm_pkg::CASE_OFFSET;
        end
        unique case (i_item.mode)
            turm_pkg::MODE_READ: begin
                unique case (i_item.reg_select)
                    turm_pkg::SEL_RBR: begin
                        n_lsr = r_lsr & ~turm_pkg::FLAG_RX_FULL;
                        rd    = r_rbr;
                    end
                    turm_pkg::SEL_LSR: rd = r_lsr;
                    turm_pkg::SEL_IER: rd = r_ier;
                    turm_pkg::SEL_IIR: rd = r_iir;
                    turm_pkg::SEL_LCR: rd = r_lcr;
                    default:           rd = 8'd0;
                endcase
            end
            turm_pkg::MODE_WRITE: begin
                unique case (i_item.reg_select)
                    turm_pkg::SEL_THR: begin
                        n_lsr = r_lsr & ~turm_pkg::FLAG_TX_EMPTY;
                        n_thr = i_item.write_data;
                    end
                    turm_pkg::SEL_IER: n_ier = i_item.write_data;
                    turm_pkg::SEL_LCR: n_lcr = i_item.write_data;
                    default: ;
                endcase
            end
            turm_pkg::MODE_TICK: begin
                if (i_item.rx_valid && (r_lsr & turm_pkg::FLAG_RX_FULL) == 8'd0) begin
                    n_rbr = rx_c;
                    n_lsr = n_lsr | turm_pkg::FLAG_RX_FULL;
                    if ((r_ier & turm_pkg::FLAG_RX_FULL) != 8'd0) begin
                        n_iir = n_iir | turm_pkg::FLAG_RX_FULL;
                        irq   = 1'b1;
                    end
                end
                if ((r_lsr & turm_pkg::FLAG_TX_EMPTY) == 8'd0) begin
                    tx_go = 1'b1;
                    n_lsr = n_lsr | turm_pkg::FLAG_TX_EMPTY;
                    if ((r_ier & turm_pkg::FLAG_TX_EMPTY) != 8'd0) begin
                        n_iir = n_iir | turm_pkg::FLAG_TX_EMPTY;
                        irq   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign is_cr = tx_go && (r_thr == turm_pkg::CHAR_CR);

    always_comb begin
        o_push.en               = i_accept;
        o_push.two              = is_cr;
        o_push.first.read_data  = rd;
        o_push.first.tx_valid   = tx_go;
        o_push.first.tx_char    = tx_go ? r_thr : 8'd0;
        o_push.first.irq        = irq;
        o_push.first.last       = !is_cr;
        o_push.second.read_data = 8'd0;
        o_push.second.tx_valid  = 1'b1;
        o_push.second.tx_char   = turm_pkg::CHAR_LF;
        o_push.second.irq       = irq;
        o_push.second.last      = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbr <= 8'd0;
            r_thr <= 8'd0;
            r_lsr <= turm_pkg::LSR_RESET;
            r_ier <= 8'd0;
            r_iir <= 8'd0;
            r_lcr <= 8'd0;
        end else if (i_accept) begin
            r_rbr <= n_rbr;
            r_thr <= n_thr;
            r_lsr <= n_lsr;
            r_ier <= n_ier;
            r_iir <= n_iir;
            r_lcr <= n_lcr;
        end
    end

endmodule

/* rtl/core/turm_obuf.sv */
`timescale 1ns / 1ps

module turm_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  turm_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output turm_pkg::t_out_item o_item
);

    turm_pkg::t_out_item r_mem [turm_pkg::OBUF_DEPTH];
    logic [turm_pkg::OBUF_AW-1:0] r_head, r_tail, n_head, n_tail;
    logic [turm_pkg::OBUF_CW-1:0] r_count, n_count;
    logic [turm_pkg::OBUF_CW-1:0] push_n;
    logic                         pop;

    // room for a two-result item
    assign o_room  = r_count <= turm_pkg::OBUF_CW'(turm_pkg::OBUF_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_head];
    assign pop     = o_valid && i_ready;

    always_comb begin
        push_n  = '0;
        if (i_push.en) begin
            push_n = i_push.two ? turm_pkg::OBUF_CW'(2) : turm_pkg::OBUF_CW'(1);
        end
        n_count = r_count + push_n - turm_pkg::OBUF_CW'(pop);
        n_tail  = r_tail + push_n[turm_pkg::OBUF_AW-1:0];
        n_head  = r_head + turm_pkg::OBUF_AW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.en) begin
            r_mem[r_tail] <= i_push.first;
            if (i_push.two) begin
                r_mem[r_tail + turm_pkg::OBUF_AW'(1)] <= i_push.second;
            end
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] SEL_SPARE6 = 3'd6;
    localparam logic [2:0] SEL_SPARE7 = 3'd7;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_ITEMS  = 500;
    localparam int STALL_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 8;
    localparam int DIR_ROWS      = 27;

    localparam turm_pkg::t_out_item ACK    = '{8'h00, 1'b0, 8'h00, 1'b0, 1'b1};
    localparam turm_pkg::t_out_item NO_RES = '0;

    typedef struct packed {
        turm_pkg::t_in_item  item;
        logic                typed;
        turm_pkg::t_out_item res;
    } t_dir_row;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    turm_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    turm_pkg::t_out_item out_item;

    int        send_idle = 6;
    int        recv_idle = 72;
    int        stall_cnt = 0;
    bit        failed    = 1'b0;

    logic [7:0] rbr_q, thr_q, lsr_q, ier_q, iir_q, lcr_q;
    turm_pkg::t_out_item step_res [2];
    turm_pkg::t_out_item pending_results [$];

    t_dir_row dir_table [DIR_ROWS] = '{
        '{'{turm_pkg::MODE_READ,  turm_pkg::SEL_LSR, 8'h00, 1'b0, 8'h00}, 1'b1,
          '{8'h40, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{'{turm_pkg::MODE_READ,  turm_pkg::SEL_THR, 8'h00, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_READ,  SEL_SPARE6,        8'h00, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_READ,  SEL_SPARE7,        8'hff, 1'b1, 8'hff}, 1'b1, ACK},
        '{'{turm_pkg::MODE_WRITE, turm_pkg::SEL_LCR, 8'hff, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_READ,  turm_pkg::SEL_LCR, 8'h00, 1'b0, 8'h00}, 1'b1,
          '{8'hff, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{'{turm_pkg::MODE_WRITE, turm_pkg::SEL_LCR, 8'h00, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_WRITE, turm_pkg::SEL_RBR, 8'h55, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_WRITE, turm_pkg::SEL_LSR, 8'hff, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_WRITE, turm_pkg::SEL_IIR, 8'hff, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_WRITE, SEL_SPARE7,        8'hff, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_READ,  turm_pkg::SEL_LSR, 8'h00, 1'b0, 8'h00}, 1'b1,
          '{8'h40, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{'{turm_pkg::MODE_WRITE, turm_pkg::SEL_IER, 8'hc0, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_TICK,  turm_pkg::SEL_RBR, 8'h00, 1'b1, 8'h61}, 1'b0, NO_RES},
        '{'{turm_pkg::MODE_TICK,  turm_pkg::SEL_RBR, 8'h00, 1'b1, 8'h62}, 1'b0, NO_RES},
        '{'{turm_pkg::MODE_READ,  turm_pkg::SEL_RBR, 8'h00, 1'b0, 8'h00}, 1'b0, NO_RES},
        '{'{turm_pkg::MODE_READ,  turm_pkg::SEL_RBR, 8'h00, 1'b0, 8'h00}, 1'b0, NO_RES},
        '{'{turm_pkg::MODE_WRITE, turm_pkg::SEL_THR, turm_pkg::CHAR_CR, 1'b0, 8'h00},
          1'b1, ACK},
        '{'{turm_pkg::MODE_WRITE, turm_pkg::SEL_THR, 8'h7a, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_TICK,  turm_pkg::SEL_RBR, 8'h00, 1'b1, 8'h7a}, 1'b0, NO_RES},
        '{'{turm_pkg::MODE_WRITE, turm_pkg::SEL_THR, turm_pkg::CHAR_CR, 1'b0, 8'h00},
          1'b1, ACK},
        '{'{turm_pkg::MODE_TICK,  turm_pkg::SEL_RBR, 8'h00, 1'b0, 8'h00}, 1'b0, NO_RES},
        '{'{turm_pkg::MODE_READ,  turm_pkg::SEL_IIR, 8'h00, 1'b0, 8'h00}, 1'b0, NO_RES},
        '{'{MODE_SPARE,           SEL_SPARE7,        8'hff, 1'b1, 8'hff}, 1'b1, ACK},
        '{'{turm_pkg::MODE_READ,  turm_pkg::SEL_RBR, 8'h00, 1'b0, 8'h00}, 1'b0, NO_RES},
        '{'{turm_pkg::MODE_WRITE, turm_pkg::SEL_IER, 8'hff, 1'b0, 8'h00}, 1'b1, ACK},
        '{'{turm_pkg::MODE_TICK,  turm_pkg::SEL_RBR, 8'h00, 1'b1, 8'hff}, 1'b0, NO_RES}
    };

    terminal_uart_register_model uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic raise_line_flag(input logic [7:0] flag);
        lsr_q = lsr_q | flag;
        if ((ier_q & flag) != 8'h00) begin
            iir_q = iir_q | flag;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int compute_uart_results(input turm_pkg::t_in_item it);
        turm_pkg::t_out_item r;
        logic [7:0]          c;
        logic                irq;
        r      = '0;
        r.last = 1'b1;
        irq    = 1'b0;
        case (it.mode)
            turm_pkg::MODE_READ: begin
                case (it.reg_select)
                    turm_pkg::SEL_RBR: begin
                        lsr_q       = lsr_q & ~turm_pkg::FLAG_RX_FULL;
                        r.read_data = rbr_q;
                    end
                    turm_pkg::SEL_LSR: r.read_data = lsr_q;
                    turm_pkg::SEL_IER: r.read_data = ier_q;
                    turm_pkg::SEL_IIR: r.read_data = iir_q;
                    turm_pkg::SEL_LCR: r.read_data = lcr_q;
                    default:           r.read_data = 8'h00;
                endcase
            end
            turm_pkg::MODE_WRITE: begin
                case (it.reg_select)
                    turm_pkg::SEL_THR: begin
                        lsr_q = lsr_q & ~turm_pkg::FLAG_TX_EMPTY;
                        thr_q = it.write_data;
                    end
                    turm_pkg::SEL_IER: ier_q = it.write_data;
                    turm_pkg::SEL_LCR: lcr_q = it.write_data;
                    default: ;
                endcase
            end
            turm_pkg::MODE_TICK: begin
                if (it.rx_valid && (lsr_q & turm_pkg::FLAG_RX_FULL) == 8'h00) begin
                    c = it.rx_char;
                    if (c >= turm_pkg::CHAR_LC_A && c <= turm_pkg::CHAR_LC_Z)
                        c = c - turm_pkg::CASE_OFFSET;
                    rbr_q = c;
                    if (raise_line_flag(turm_pkg::FLAG_RX_FULL))
                        irq = 1'b1;
                end
                if ((lsr_q & turm_pkg::FLAG_TX_EMPTY) == 8'h00) begin
                    c = thr_q;
                    if (raise_line_flag(turm_pkg::FLAG_TX_EMPTY))
                        irq = 1'b1;
                    r.tx_valid = 1'b1;
                    r.tx_char  = c;
                    r.irq      = irq;
                    if (c == turm_pkg::CHAR_CR) begin
                        r.last      = 1'b0;
                        step_res[0] = r;
                        r.tx_char   = turm_pkg::CHAR_LF;
                        r.last      = 1'b1;
                        step_res[1] = r;
                        return 2;
                    end
                end
                r.irq = irq;
            end
            default: ;
        endcase
        step_res[0] = r;
        return 1;
    endfunction

    task automatic push_item(input t_dir_row row);
        int n;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= row.item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n = compute_uart_results(row.item);
        if (row.typed)
            pending_results.push_back(row.res);
        else
            for (int k = 0; k < n; k++) pending_results.push_back(step_res[k]);
    endtask

    always @(posedge clk) begin
        turm_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, actual %h", $time, out_item);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (out_item.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             want.read_data, out_item.read_data);
                    failed = 1'b1;
                end
                if (out_item.tx_valid !== want.tx_valid) begin
                    $display("%0t: tx_valid expected %b actual %b", $time,
                             want.tx_valid, out_item.tx_valid);
                    failed = 1'b1;
                end
                if (out_item.tx_char !== want.tx_char) begin
                    $display("%0t: tx_char expected %h actual %h", $time,
                             want.tx_char, out_item.tx_char);
                    failed = 1'b1;
                end
                if (out_item.irq !== want.irq) begin
                    $display("%0t: irq expected %b actual %b", $time,
                             want.irq, out_item.irq);
                    failed = 1'b1;
                end
                if (out_item.last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             want.last, out_item.last);
                    failed = 1'b1;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cnt <= 0;
            else if (stall_cnt >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else
                stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        t_dir_row row;
        int       roll;
        rbr_q = 8'h00;
        thr_q = 8'h00;
        lsr_q = turm_pkg::LSR_RESET;
        ier_q = 8'h00;
        iir_q = 8'h00;
        lcr_q = 8'h00;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            push_item(dir_table[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                // drain fully before swapping the idle pattern
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
                send_idle = 72;
                recv_idle = 6;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            row                 = '0;
            row.item.write_data = 8'($urandom);
            row.item.rx_valid   = 1'($urandom_range(1));
            row.item.rx_char    = ($urandom_range(1) != 0) ? 8'($urandom) :
                8'($urandom_range(turm_pkg::CHAR_LC_A, turm_pkg::CHAR_LC_Z));
            row.item.reg_select = 3'($urandom_range(7));
            roll = $urandom_range(99);
            if (roll < 32) begin
                row.item.mode     = turm_pkg::MODE_TICK;
                row.item.rx_valid = ($urandom_range(3) != 0);
            end else if (roll < 57) begin
                row.item.mode = turm_pkg::MODE_WRITE;
                if ($urandom_range(3) != 0)
                    row.item.reg_select = ($urandom_range(2) != 0) ?
                                          turm_pkg::SEL_THR : turm_pkg::SEL_IER;
                if (row.item.reg_select == turm_pkg::SEL_THR && $urandom_range(3) == 0)
                    row.item.write_data = turm_pkg::CHAR_CR;
            end else if (roll < 95) begin
                row.item.mode = turm_pkg::MODE_READ;
                if ($urandom_range(1) != 0)
                    row.item.reg_select = turm_pkg::SEL_RBR;
            end else begin
                row.item.mode = MODE_SPARE;
            end
            push_item(row);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* terminal_uart_register_model.f */
rtl/core/turm_pkg.sv
rtl/core/turm_core.sv
rtl/core/turm_obuf.sv
rtl/core/terminal_uart_register_model.sv
verif/tb.sv
